/* rtl/lgps_pkg.sv */
// Shared types, register map, reset values and the per-tick sequence step.
package lgps_pkg;

    localparam int LIGHT_W  = 10;
    localparam int COUNT_W  = 6;
    localparam int LOWBAT_W = 8;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_LIGHT_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_SETTLE_TICKS    = 2'd1;
    localparam logic [1:0] REG_SWITCH_TICKS    = 2'd2;
    localparam logic [1:0] REG_LOWBAT_LIMIT    = 2'd3;

    // Register reset values
    localparam logic [LIGHT_W-1:0]  RST_LIGHT_THRESHOLD = 10'd490;
    localparam logic [COUNT_W-1:0]  RST_SETTLE_TICKS    = 6'd10;
    localparam logic [COUNT_W-1:0]  RST_SWITCH_TICKS    = 6'd30;
    localparam logic [LOWBAT_W-1:0] RST_LOWBAT_LIMIT    = 8'd60;

    // State reset values
    localparam logic [COUNT_W-1:0]  RST_BRIGHT_COUNT = 6'd0;
    localparam logic [COUNT_W-1:0]  RST_DARK_COUNT   = 6'd31;
    localparam logic [LOWBAT_W-1:0] RST_LOWBAT_COUNT = 8'd0;

    localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [LOWBAT_W-1:0] LOWBAT_MAX = {LOWBAT_W{1'b1}};

    typedef struct packed {
        logic [LIGHT_W-1:0]  light_threshold;
        logic [COUNT_W-1:0]  settle_ticks;
        logic [COUNT_W-1:0]  switch_ticks;
        logic [LOWBAT_W-1:0] lowbat_limit;
    } cfg_t;

    typedef struct packed {
        logic relay;
        logic save_off;
        logic status;
        logic indicator;
    } levels_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] other;
        levels_t            lv;
    } seq_t;

    // One bright or dark step: bump this count, maybe clear the other one,
    // and move the output levels along the sequence.
    function automatic seq_t seq_step(
        input logic [COUNT_W-1:0] count,
        input logic [COUNT_W-1:0] other,
        input logic               bright,
        input logic [COUNT_W-1:0] settle,
        input logic [COUNT_W-1:0] sw,
        input levels_t            lv
    );
        seq_t r;
        r.count = (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;
        r.other = other;
        r.lv    = lv;
        if (r.count > settle)
        begin
            r.other = '0;
            if (r.count < sw)
            begin
                r.lv.indicator = r.count[0];
                r.lv.status    = bright;
                r.lv.save_off  = bright;
            end
            else if (r.count > sw)
            begin
                if (bright)
                begin
                    r.lv.save_off  = 1'b1;
                    r.lv.relay     = 1'b1;
                    r.lv.status    = 1'b0;
                    r.lv.indicator = 1'b1;
                end
                else
                begin
                    r.lv.status    = 1'b0;
                    r.lv.indicator = 1'b0;
                    r.lv.relay     = 1'b0;
                end
                r.count = (sw == COUNT_MAX) ? COUNT_MAX : sw + 1'b1;
            end
        end
        else
        begin
            r.lv.indicator = r.count[0];
        end
        return r;
    endfunction

endpackage

/* rtl/lgps_cfg.sv */
// Configuration register bank behind the APB-style port.
module lgps_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lgps_pkg::ADDR_W-1:0] paddr,
    input  logic [lgps_pkg::DATA_W-1:0] pwdata,
    output logic [lgps_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lgps_pkg::cfg_t             cfg
);
    import lgps_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.light_threshold <= RST_LIGHT_THRESHOLD;
            cfg_reg.settle_ticks    <= RST_SETTLE_TICKS;
            cfg_reg.switch_ticks    <= RST_SWITCH_TICKS;
            cfg_reg.lowbat_limit    <= RST_LOWBAT_LIMIT;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_LIGHT_THRESHOLD: cfg_reg.light_threshold <= pwdata[LIGHT_W-1:0];
                REG_SETTLE_TICKS:    cfg_reg.settle_ticks    <= pwdata[COUNT_W-1:0];
                REG_SWITCH_TICKS:    cfg_reg.switch_ticks    <= pwdata[COUNT_W-1:0];
                REG_LOWBAT_LIMIT:    cfg_reg.lowbat_limit    <= pwdata[LOWBAT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_LIGHT_THRESHOLD:
                prdata = {{(DATA_W-LIGHT_W){1'b0}}, cfg_reg.light_threshold};
            REG_SETTLE_TICKS:
                prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_reg.settle_ticks};
            REG_SWITCH_TICKS:
                prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_reg.switch_ticks};
            REG_LOWBAT_LIMIT:
                prdata = {{(DATA_W-LOWBAT_W){1'b0}}, cfg_reg.lowbat_limit};
            default:
                prdata = '0;
        endcase
    end

endmodule

/* rtl/lgps_core.sv */
// Input register, sequencer state, next-state logic and result register.
module lgps_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lgps_pkg::cfg_t               cfg,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_low,
    input  logic [lgps_pkg::LIGHT_W-1:0] in_light,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lgps_pkg::levels_t            out_levels
);
    import lgps_pkg::*;

    logic                in_valid_reg;
    logic                in_low_reg;
    logic [LIGHT_W-1:0]  in_light_reg;

    logic [COUNT_W-1:0]  bright_reg, bright_next;
    logic [COUNT_W-1:0]  dark_reg, dark_next;
    logic [LOWBAT_W-1:0] lowbat_reg, lowbat_next;
    levels_t             lv_reg, lv_next;

    logic                out_valid_reg;
    levels_t             out_levels_reg;

    logic                advance;
    seq_t                seq;

    // Item moves on when the result slot is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_levels = out_levels_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_low_reg   <= in_low;
            in_light_reg <= in_light;
        end
    end

    // Tick step
    always_comb
    begin
        bright_next = bright_reg;
        dark_next   = dark_reg;
        lowbat_next = lowbat_reg;
        lv_next     = lv_reg;
        seq         = '0;
        if (in_low_reg)
        begin
            lv_next.save_off  = 1'b0;
            lv_next.status    = 1'b1;
            lv_next.indicator = 1'b0;
            lowbat_next = (lowbat_reg == LOWBAT_MAX) ? LOWBAT_MAX : lowbat_reg + 1'b1;
        end
        else
        begin
            lowbat_next = '0;
        end

        if (in_low_reg && (lowbat_next > cfg.lowbat_limit))
        begin
            // forced shutdown, light counts untouched
            lv_next.status    = 1'b0;
            lv_next.indicator = 1'b0;
            lv_next.relay     = 1'b0;
            lowbat_next = (cfg.lowbat_limit == LOWBAT_MAX) ? LOWBAT_MAX
                                                           : cfg.lowbat_limit + 1'b1;
        end
        else if (in_light_reg > cfg.light_threshold)
        begin
            if (lowbat_next == '0)
            begin
                seq = seq_step(bright_reg, dark_reg, 1'b1,
                               cfg.settle_ticks, cfg.switch_ticks, lv_next);
                bright_next = seq.count;
                dark_next   = seq.other;
                lv_next     = seq.lv;
            end
        end
        else
        begin
            seq = seq_step(dark_reg, bright_reg, 1'b0,
                           cfg.settle_ticks, cfg.switch_ticks, lv_next);
            dark_next   = seq.count;
            bright_next = seq.other;
            lv_next     = seq.lv;
        end
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bright_reg      <= RST_BRIGHT_COUNT;
            dark_reg        <= RST_DARK_COUNT;
            lowbat_reg      <= RST_LOWBAT_COUNT;
            lv_reg.relay    <= 1'b0;
            lv_reg.save_off <= 1'b1;
            lv_reg.status   <= 1'b0;
            lv_reg.indicator <= 1'b0;
        end
        else if (advance)
        begin
            bright_reg <= bright_next;
            dark_reg   <= dark_next;
            lowbat_reg <= lowbat_next;
            lv_reg     <= lv_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_levels_reg <= lv_next;
    end

endmodule

/* rtl/light_gated_power_sequencer_unit.sv */
// Light-gated power sequencer: stream ports, register port and the tick core.
// Path: an accepted word passes through the input register, then the result register.
// Throughput: one word per cycle; the input register buffers a word while the
// result register waits, so input stalls only when both are full.
// Reset (rst_n low, asynchronous): registers take their defaults, counts and
// levels take their power-up values, and both stream sides hold no word.
module light_gated_power_sequencer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    // tdata: [0] low_battery, [10:1] light_level, [15:11] zero
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,
    // tdata: [0] relay_on, [1] power_save_off, [2] status_led,
    //        [3] indicator_led, [7:4] zero
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lgps_pkg::ADDR_W-1:0] paddr,
    input  logic [lgps_pkg::DATA_W-1:0] pwdata,
    output logic [lgps_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import lgps_pkg::*;

    cfg_t    cfg;
    levels_t out_levels;

    lgps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lgps_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_low     (s_axis_tdata[0]),
        .in_light   (s_axis_tdata[LIGHT_W:1]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_levels (out_levels)
    );

    // Result word packing
    assign m_axis_tdata = {4'b0000, out_levels.indicator, out_levels.status,
                           out_levels.save_off, out_levels.relay};

endmodule

/* rtl/lgps_checker.sv */
// Port-level checks for the sequencer and the bind that attaches them.
module lgps_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [7:0]                  m_axis_tdata,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [lgps_pkg::ADDR_W-1:0] paddr,
    input logic [lgps_pkg::DATA_W-1:0] pwdata,
    input logic [lgps_pkg::DATA_W-1:0] prdata,
    input logic                        pready
);
    import lgps_pkg::*;

    // A stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // With the result slot empty the input side never stalls
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result slot");

    // A fresh result word comes from an input word accepted earlier
    a_rise_from_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result word without matching input word");

    // A threshold write reads back on the next cycle
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[3:2] == REG_LIGHT_THRESHOLD))
        ##1 (paddr[3:2] == REG_LIGHT_THRESHOLD)
        |-> (prdata[LIGHT_W-1:0] == $past(pwdata[LIGHT_W-1:0])))
        else $error("threshold register readback mismatch");

endmodule

bind light_gated_power_sequencer_unit lgps_checker u_lgps_checker (.*);
